// ----- src/drc_pkg.sv -----
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants for the daisy-chain order rebuild block.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int NODE_ID_SPAN   = 16;
  localparam int NODE_COUNT_DEF = 16;
  localparam int ROOT_NODE      = 0;

  typedef struct packed {
    logic [3:0] node_id;
    logic [7:0] master_id;
  } in_t;

  typedef struct packed {
    logic [3:0] chain_position;
    logic [3:0] chain_node;
    logic [4:0] chain_length;
    logic       last_in_chain;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_PICK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic pick;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic last;
  } sts_t;

endpackage

// ----- src/drc_ctrl.sv -----
// ----------------------------------------------------------------------------
// drc_ctrl
// Sequencer for table write, successor search and chain readout.
// ----------------------------------------------------------------------------
module drc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  drc_pkg::sts_t sts,
  output drc_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  import drc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = sts.found ? ST_MATCH : ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        out_valid = 1'b1;
        if (sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/drc_dp.sv -----
// ----------------------------------------------------------------------------
// drc_dp
// Master table, used/valid flags, successor search and chain order buffer.
// ----------------------------------------------------------------------------
module drc_dp #(
  parameter int NODE_COUNT = drc_pkg::NODE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  drc_pkg::cmd_t cmd,
  input  drc_pkg::in_t  in_item,
  output drc_pkg::sts_t sts,
  output drc_pkg::out_t out_item
);
  import drc_pkg::*;

  localparam int TBL_DEPTH = (NODE_COUNT < NODE_ID_SPAN) ? NODE_COUNT : NODE_ID_SPAN;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int LEN_W     = $clog2(TBL_DEPTH + 1);

  logic [7:0]           table_r [TBL_DEPTH];
  logic [IDX_W-1:0]     order_r [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] valid_r;
  logic [TBL_DEPTH-1:0] used_r;
  logic [TBL_DEPTH-1:0] cand_r;
  logic [TBL_DEPTH-1:0] cand_nxt;
  logic [IDX_W-1:0]     cur_r;
  logic [LEN_W-1:0]     len_r;
  logic [IDX_W-1:0]     pos_r;
  logic [IDX_W-1:0]     pick_idx;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;

  assign wr_en  = cmd.load && (int'(in_item.node_id) < NODE_COUNT);
  assign wr_idx = in_item.node_id[IDX_W-1:0];

  always_comb begin
    for (int j = 0; j < TBL_DEPTH; j++) begin
      cand_nxt[j] = valid_r[j] && !used_r[j] && (table_r[j] == 8'(cur_r));
    end
  end

  always_comb begin
    pick_idx = '0;
    for (int j = TBL_DEPTH - 1; j >= 0; j--) begin
      if (cand_r[j]) begin
        pick_idx = IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_r[wr_idx] <= in_item.master_id;
    end
    if (cmd.load) begin
      order_r[0] <= IDX_W'(ROOT_NODE);
    end else if (cmd.pick && (cand_r != '0)) begin
      order_r[len_r[IDX_W-1:0]] <= pick_idx;
    end
    if (cmd.match) begin
      cand_r <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= TBL_DEPTH'(1) << ROOT_NODE;
      used_r  <= TBL_DEPTH'(1) << ROOT_NODE;
      cur_r   <= IDX_W'(ROOT_NODE);
      len_r   <= LEN_W'(1);
      pos_r   <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (cmd.load) begin
        used_r <= TBL_DEPTH'(1) << ROOT_NODE;
        cur_r  <= IDX_W'(ROOT_NODE);
        len_r  <= LEN_W'(1);
        pos_r  <= '0;
      end else if (cmd.pick && (cand_r != '0)) begin
        used_r[pick_idx] <= 1'b1;
        cur_r            <= pick_idx;
        len_r            <= len_r + LEN_W'(1);
      end else if (cmd.emit) begin
        pos_r <= pos_r + IDX_W'(1);
      end
    end
  end

  assign sts.found = (cand_r != '0);
  assign sts.last  = ((LEN_W'(pos_r) + LEN_W'(1)) == len_r);

  assign out_item.chain_position = 4'(pos_r);
  assign out_item.chain_node     = 4'(order_r[pos_r]);
  assign out_item.chain_length   = 5'(len_r);
  assign out_item.last_in_chain  = sts.last;

endmodule

// ----- src/daisy_chain_order_rebuild.sv -----
// ----------------------------------------------------------------------------
// daisy_chain_order_rebuild
// Stores node master reports and reads out the chain rebuilt from root node 0.
// ----------------------------------------------------------------------------
//  Channel   Ports                       Transfer
//  input     start, busy, in_item        start high while busy low
//  result    out_valid, out_item         every cycle out_valid is high
//
//  A report holds busy through the search and the readout, L = chain length
//  (1..16): a match and a pick state per search step over the master table
//  (L steps, the last finds nothing), then one result per cycle.
//  Reset brings back an empty table with only the root valid.
//  Results cannot be stalled; each is on the ports for one cycle.
// ----------------------------------------------------------------------------
module daisy_chain_order_rebuild #(
  parameter int NODE_COUNT = drc_pkg::NODE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  drc_pkg::in_t  in_item,
  output logic          out_valid,
  output drc_pkg::out_t out_item
);
  import drc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  drc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  drc_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

// ----- src/drc_checker.sv -----
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks on transfer sequencing of the chain readout.
// ----------------------------------------------------------------------------
module drc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input drc_pkg::out_t out_item
);
  import drc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_first_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |->
      (out_item.chain_position == 4'd0 && out_item.chain_node == 4'd0))
    else $error("readout does not open with the root");

  a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_in_chain) |=>
      (out_valid && out_item.chain_position == $past(out_item.chain_position) + 4'd1
       && $stable(out_item.chain_length)))
    else $error("readout position or length broken");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_in_chain) |=> (!out_valid && !busy))
    else $error("readout continues after last result");

endmodule

bind daisy_chain_order_rebuild drc_checker u_drc_checker (.*);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for daisy_chain_order_rebuild: sends node reports through the
// start/busy handshake, keeps its own copy of the master table and walks
// the chain from root node 0 to predict each readout. Every strobed result
// is checked field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drc_pkg::*;

  localparam int          NODE_COUNT     = NODE_COUNT_DEF;
  localparam logic [7:0]  MASTER_UNKNOWN = 8'hFF;
  localparam int          RANDOM_REPORTS = 136;
  localparam int          CYCLE_LIMIT    = 100000;
  localparam int          DRAIN_CYCLES   = 64;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  logic [7:0] node_master [NODE_COUNT];
  bit         node_known  [NODE_COUNT];
  out_t       chain_expect [$];
  int         mismatch_count;
  int         cycle_count;

  daisy_chain_order_rebuild #(
    .NODE_COUNT(NODE_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_master_table();
    for (int n = 0; n < NODE_COUNT; n++) begin
      node_known[n]  = 1'b0;
      node_master[n] = '0;
    end
    node_known[ROOT_NODE]  = 1'b1;
    node_master[ROOT_NODE] = MASTER_UNKNOWN;
  endfunction

  // store the report, walk from root, queue one readout entry per chain node
  function automatic void predict_chain_readout(input in_t report);
    bit   visited [NODE_COUNT];
    int   order [$];
    int   cur;
    int   pick;
    bit   hit;
    out_t res;
    if (int'(report.node_id) < NODE_COUNT) begin
      node_master[report.node_id] = report.master_id;
      node_known[report.node_id]  = 1'b1;
    end
    for (int n = 0; n < NODE_COUNT; n++) visited[n] = 1'b0;
    visited[ROOT_NODE] = 1'b1;
    order.push_back(ROOT_NODE);
    cur = ROOT_NODE;
    for (int step = 0; step + 1 < NODE_COUNT && order.size() < NODE_ID_SPAN; step++) begin
      hit  = 1'b0;
      pick = 0;
      for (int j = 0; j < NODE_COUNT; j++) begin
        if (!visited[j] && node_known[j] && int'(node_master[j]) == cur) begin
          hit  = 1'b1;
          pick = j;
          break;
        end
      end
      if (!hit) break;
      order.push_back(pick);
      visited[pick] = 1'b1;
      cur = pick;
    end
    for (int k = 0; k < order.size(); k++) begin
      res.chain_position = 4'(k);
      res.chain_node     = 4'(order[k]);
      res.chain_length   = 5'(order.size());
      res.last_in_chain  = (k == order.size() - 1);
      chain_expect.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (chain_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result node=%0d pos=%0d",
                                  out_item.chain_node, out_item.chain_position));
      end else begin
        want = chain_expect.pop_front();
        if (out_item.chain_position !== want.chain_position)
          report_mismatch($sformatf("chain_position got %0d want %0d",
                                    out_item.chain_position, want.chain_position));
        if (out_item.chain_node !== want.chain_node)
          report_mismatch($sformatf("chain_node got %0d want %0d at pos %0d",
                                    out_item.chain_node, want.chain_node,
                                    want.chain_position));
        if (out_item.chain_length !== want.chain_length)
          report_mismatch($sformatf("chain_length got %0d want %0d",
                                    out_item.chain_length, want.chain_length));
        if (out_item.last_in_chain !== want.last_in_chain)
          report_mismatch($sformatf("last_in_chain got %0b want %0b at pos %0d",
                                    out_item.last_in_chain, want.last_in_chain,
                                    want.chain_position));
      end
    end
  end

  function automatic int pick_gap(input bit gapless);
    int r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // keep start low through the gap, then hold start until the transfer
  task automatic send_report(input logic [3:0] node, input logic [7:0] master,
                             input int gap);
    in_t report;
    report.node_id   = node;
    report.master_id = master;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= report;
    do @(posedge clk); while (busy);
    predict_chain_readout(report);
  endtask

  task automatic wait_chain_drained();
    @(negedge clk);
    start <= 1'b0;
    while (chain_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_root_report();
    send_report(4'd0, MASTER_UNKNOWN, pick_gap(1'b0));
    send_report(4'd0, 8'h00, pick_gap(1'b0));
  endtask

  task automatic test_unknown_master();
    send_report(4'd15, 8'(NODE_COUNT), pick_gap(1'b0));
    send_report(4'd15, MASTER_UNKNOWN, pick_gap(1'b0));
    send_report(4'd7, 8'h80, pick_gap(1'b0));
  endtask

  task automatic test_lowest_candidate_and_cycle();
    send_report(4'd9, 8'd0, pick_gap(1'b0));
    send_report(4'd4, 8'd0, pick_gap(1'b0));
    send_report(4'd4, 8'd9, pick_gap(1'b0));
    send_report(4'd9, 8'd4, pick_gap(1'b0));
  endtask

  // link tail first so the chain only closes on the last report
  task automatic test_full_chain();
    for (int n = NODE_COUNT - 1; n >= 1; n--)
      send_report(4'(n), 8'(n - 1), pick_gap(1'b0));
  endtask

  task automatic test_random_reports();
    bit         gapless;
    int         r;
    logic [3:0] node;
    logic [7:0] master;
    gapless = 1'b0;
    for (int i = 0; i < RANDOM_REPORTS; i++) begin
      if (i % 20 == 0) gapless = ($urandom_range(0, 2) == 0);
      r    = $urandom_range(0, 99);
      node = 4'($urandom_range(0, NODE_COUNT - 1));
      if (r < 40)
        master = (node == 0) ? MASTER_UNKNOWN : 8'(node - 1);
      else if (r < 75)
        master = 8'($urandom_range(0, NODE_COUNT - 1));
      else if (r < 90)
        master = 8'($urandom_range(NODE_COUNT, 255));
      else
        master = 8'($urandom_range(0, 255));
      send_report(node, master, pick_gap(gapless));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    clear_master_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_root_report();
    test_unknown_master();
    test_lowest_candidate_and_cycle();
    test_full_chain();
    test_random_reports();
    wait_chain_drained();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
